// ===== hdl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared codes and field widths for the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  // Transaction kinds carried on s_axis_tuser
  localparam logic [1:0] FUNC_PATTERN = 2'd0;  // write one pattern character
  localparam logic [1:0] FUNC_TEXT    = 2'd1;  // one text byte
  localparam logic [1:0] FUNC_RESTART = 2'd2;  // restart the text

  localparam int FUNC_W = 2;
  localparam int PID_W  = 2;
  localparam int CPOS_W = 4;
  localparam int CHAR_W = 8;
  localparam int MPAT_W = 2;
  localparam int SPOS_W = 10;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [SPOS_W-1:0] spos_t;

endpackage

// ===== hdl/multi_pattern_string_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Finds all occurrences, overlapping ones too, of several byte patterns in a
// streamed byte text and reports pattern number and start position of each.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                       | content
//  s_axis   | in        | tvalid tready tdata tuser     | pattern write / text byte / restart
//  m_axis   | out       | tvalid tready tdata tlast     | one match per transaction
//
//  An input transaction is taken when no match is pending; window update and all
//  pattern compares happen in the accept cycle and land in the result regs.
//  A text byte with k matches holds the output for k transactions, in rising
//  pattern order; the next input is taken in the cycle its final one leaves.
//  Reset empties all patterns, zeroes the position and drops pending results.
//  Pattern characters and the text window are not reset.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher #(
  parameter int NUM_PATTERNS = 4,
  parameter int PATTERN_LEN  = 16,
  parameter int TEXT_LEN     = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,

  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [1:0] pattern_id, [5:2] char_pos, [13:6] char_value, [15:14] zero
  input  logic [mpsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [1:0] func
  input  logic [mpsm_pkg::FUNC_W-1:0]          s_axis_tuser,

  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] match_pattern, [11:2] start_position, [15:12] zero
  output logic [mpsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam int LEN_W = $clog2(PATTERN_LEN + 1);
  localparam int POS_W = $clog2(TEXT_LEN + 1);
  localparam int PAD_W = mpsm_pkg::OUT_TDATA_W - mpsm_pkg::SPOS_W - mpsm_pkg::MPAT_W;

  logic [mpsm_pkg::FUNC_W-1:0] func;
  logic [mpsm_pkg::PID_W-1:0]  pattern_id;
  logic [mpsm_pkg::CPOS_W-1:0] char_pos;
  mpsm_pkg::char_t             char_value;

  mpsm_pkg::char_t             pattern [NUM_PATTERNS][PATTERN_LEN];
  logic [LEN_W-1:0]            pattern_len [NUM_PATTERNS];
  mpsm_pkg::char_t             window [PATTERN_LEN];
  mpsm_pkg::char_t             window_next [PATTERN_LEN];
  logic [POS_W-1:0]            text_position;

  logic [NUM_PATTERNS-1:0]     hit;
  mpsm_pkg::spos_t             hit_start [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0]     pending;
  mpsm_pkg::spos_t             pending_start [NUM_PATTERNS];

  logic                        in_fire;
  logic                        out_fire;
  logic                        text_full;
  logic                        text_take;
  logic                        text_clear;
  logic                        pat_write;

  logic [NUM_PATTERNS-1:0]     sel;
  logic [mpsm_pkg::MPAT_W-1:0] out_pattern;
  mpsm_pkg::spos_t             out_start;

  assign func       = s_axis_tuser;
  assign pattern_id = s_axis_tdata[1:0];
  assign char_pos   = s_axis_tdata[5:2];
  assign char_value = s_axis_tdata[13:6];

  assign in_fire    = s_axis_tvalid & s_axis_tready;
  assign out_fire   = m_axis_tvalid & m_axis_tready;

  assign text_full  = (32'(text_position) >= TEXT_LEN);
  assign text_take  = in_fire && (func == mpsm_pkg::FUNC_TEXT) &&
                      (char_value != '0) && !text_full;
  assign text_clear = in_fire && ((func == mpsm_pkg::FUNC_RESTART) ||
                      ((func == mpsm_pkg::FUNC_TEXT) && (char_value == '0)));
  assign pat_write  = in_fire && (func == mpsm_pkg::FUNC_PATTERN);

  // newest byte at index 0
  always_comb begin
    window_next[0] = char_value;
    for (int i = 1; i < PATTERN_LEN; i++) begin
      window_next[i] = window[i-1];
    end
  end

  mpsm_match #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .PATTERN_LEN  (PATTERN_LEN),
    .TEXT_LEN     (TEXT_LEN)
  ) u_match (
    .window        (window_next),
    .pattern       (pattern),
    .pattern_len   (pattern_len),
    .text_position (text_position),
    .hit           (hit),
    .start         (hit_start)
  );

  // pattern characters, no reset
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      for (int j = 0; j < PATTERN_LEN; j++) begin
        if (pat_write && (32'(pattern_id) == p) && (32'(char_pos) == j)) begin
          pattern[p][j] <= char_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        pattern_len[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (pat_write && (32'(pattern_id) == p) && (32'(char_pos) < PATTERN_LEN)) begin
          pattern_len[p] <= (char_value != '0) ? LEN_W'(32'(char_pos) + 1)
                                               : LEN_W'(char_pos);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
    end else if (text_clear) begin
      text_position <= '0;
    end else if (text_take) begin
      text_position <= text_position + POS_W'(1);
    end
  end

  // result registers: one pending flag per pattern, drained lowest first
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (text_take) begin
      pending <= hit;
    end else if (out_fire) begin
      pending <= pending & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      pending_start <= hit_start;
    end
  end

  always_comb begin
    sel         = '0;
    out_pattern = '0;
    out_start   = pending_start[0];
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (pending[p]) begin
        sel         = '0;
        sel[p]      = 1'b1;
        out_pattern = mpsm_pkg::MPAT_W'(p);
        out_start   = pending_start[p];
      end
    end
  end

  assign m_axis_tvalid = |pending;
  assign m_axis_tlast  = ((pending & ~sel) == '0);
  assign m_axis_tdata  = {PAD_W'(0), out_start, out_pattern};

  assign s_axis_tready = ~m_axis_tvalid | (m_axis_tready & m_axis_tlast);

endmodule

// ===== hdl/mpsm_match.sv =====
// ----------------------------------------------------------------------------
// mpsm_match
// Compares every pattern against the updated text window in parallel and
// gives a hit flag and a start position for each pattern.
// ----------------------------------------------------------------------------
module mpsm_match #(
  parameter int NUM_PATTERNS = 4,
  parameter int PATTERN_LEN  = 16,
  parameter int TEXT_LEN     = 1024
) (
  input  mpsm_pkg::char_t                              window [PATTERN_LEN],
  input  mpsm_pkg::char_t                              pattern [NUM_PATTERNS][PATTERN_LEN],
  input  logic [$clog2(PATTERN_LEN+1)-1:0]             pattern_len [NUM_PATTERNS],
  input  logic [$clog2(TEXT_LEN+1)-1:0]                text_position,
  output logic [NUM_PATTERNS-1:0]                      hit,
  output mpsm_pkg::spos_t                              start [NUM_PATTERNS]
);

  localparam int WIDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;

  always_comb begin
    int                len;
    int                back;
    logic [WIDX_W-1:0] widx;
    logic              all_ok;
    mpsm_pkg::char_t   pc;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      len    = 32'(pattern_len[p]);
      all_ok = (len != 0) && (len <= PATTERN_LEN) && (32'(text_position) + 1 >= len);
      for (int j = 0; j < PATTERN_LEN; j++) begin
        // pattern char j lines up with the byte len-1-j places back from the newest
        back = len - 1 - j;
        widx = WIDX_W'(back);
        pc   = pattern[p][j];
        if (j < len) begin
          if ((pc == '0) || (pc != window[widx])) begin
            all_ok = 1'b0;
          end
        end
      end
      hit[p]   = all_ok;
      start[p] = mpsm_pkg::SPOS_W'(32'(text_position) + 1 - len);
    end
  end

endmodule

// ===== tb/sv/multi_pattern_string_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_test
// Self-checking bench for the multi-pattern string matcher. A short table of
// pattern loads, text bytes and restarts comes first, then random pattern
// loads, pokes, restarts, unused codes and text runs. Every match transaction
// is checked against an in-bench predictor, with random stalls on both stream ports.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_test;

  localparam int NUM_PAT      = 4;
  localparam int PAT_LEN      = 16;
  localparam int TEXT_MAX     = 1024;
  localparam int RANDOM_ITEMS = 290;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [mpsm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [mpsm_pkg::MPAT_W-1:0] pat;
    mpsm_pkg::spos_t             start;
    logic                        last;
  } match_t;

  typedef struct packed {
    logic [mpsm_pkg::FUNC_W-1:0] f;
    logic [mpsm_pkg::PID_W-1:0]  pid;
    logic [mpsm_pkg::CPOS_W-1:0] cpos;
    mpsm_pkg::char_t             cval;
    logic                        typed;   // row carries a hand-written expectation
    logic [2:0]                  n;
    logic [mpsm_pkg::MPAT_W-1:0] lpat;
    mpsm_pkg::spos_t             lstart;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [mpsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [mpsm_pkg::FUNC_W-1:0]      s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [mpsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  multi_pattern_string_matcher #(
    .NUM_PATTERNS(NUM_PAT),
    .PATTERN_LEN (PAT_LEN),
    .TEXT_LEN    (TEXT_MAX)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // predictor state
  mpsm_pkg::char_t    pat_chars   [NUM_PAT][PAT_LEN];
  logic [4:0]         pat_len     [NUM_PAT];
  logic [PAT_LEN-1:0] pat_written [NUM_PAT];
  mpsm_pkg::char_t    window      [PAT_LEN];   // index 0 is the newest byte
  int                 text_pos;
  match_t             match_q[$];

  int     fail_cnt   = 0;
  int     cycle_cnt  = 0;
  int     sent_cnt   = 0;
  int     sink_stall = 0;
  bit     steady     = 1'b0;
  int     last_n;
  match_t last_hit;

  dir_row_t dir_tab [20] = '{
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'h61, 1'b1, 3'd0, 2'd0, 10'd0},  // all empty
    '{mpsm_pkg::FUNC_PATTERN, 2'd0, 4'd0,  8'h61, 1'b0, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_PATTERN, 2'd0, 4'd1,  8'h62, 1'b0, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_PATTERN, 2'd0, 4'd2,  8'h00, 1'b0, 3'd0, 2'd0, 10'd0},  // terminator
    '{mpsm_pkg::FUNC_PATTERN, 2'd3, 4'd0,  8'h62, 1'b0, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_PATTERN, 2'd1, 4'd0,  8'hff, 1'b0, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_RESTART, 2'd0, 4'd0,  8'h00, 1'b1, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'h61, 1'b1, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'h62, 1'b1, 3'd2, 2'd3, 10'd1},  // "ab", "b"
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'hff, 1'b1, 3'd1, 2'd1, 10'd2},
    '{mpsm_pkg::FUNC_RESTART, 2'd0, 4'd0,  8'h00, 1'b1, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'h62, 1'b1, 3'd1, 2'd3, 10'd0},  // too short
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'h00, 1'b1, 3'd0, 2'd0, 10'd0},  // zero byte
    '{FUNC_UNUSED,            2'd3, 4'd15, 8'hff, 1'b1, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_PATTERN, 2'd3, 4'd0,  8'h61, 1'b0, 3'd0, 2'd0, 10'd0},  // rewrite
    '{mpsm_pkg::FUNC_PATTERN, 2'd0, 4'd1,  8'h00, 1'b0, 3'd0, 2'd0, 10'd0},  // now "a"
    '{mpsm_pkg::FUNC_PATTERN, 2'd1, 4'd0,  8'h61, 1'b0, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_PATTERN, 2'd2, 4'd0,  8'h61, 1'b0, 3'd0, 2'd0, 10'd0},
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'h61, 1'b1, 3'd4, 2'd3, 10'd0},  // all four
    '{mpsm_pkg::FUNC_TEXT,    2'd0, 4'd0,  8'h61, 1'b1, 3'd4, 2'd3, 10'd1}
  };

  function automatic bit pattern_hits(int p);
    int len;
    len = pat_len[p];
    if (len == 0 || text_pos < len) return 1'b0;
    for (int j = 0; j < len; j++)
      if (pat_chars[p][j] == 8'h00 || pat_chars[p][j] != window[len-1-j]) return 1'b0;
    return 1'b1;
  endfunction

  // Updates the predictor for one accepted transaction and queues its matches.
  task automatic predict_matches(input logic [mpsm_pkg::FUNC_W-1:0] f,
                                 input logic [mpsm_pkg::PID_W-1:0] pid,
                                 input logic [mpsm_pkg::CPOS_W-1:0] cpos,
                                 input mpsm_pkg::char_t cval,
                                 output int n, output match_t last_m);
    match_t m;
    int     end_idx;
    n = 0;
    last_m = '0;
    case (f)
      mpsm_pkg::FUNC_PATTERN: begin
        pat_chars[pid][cpos] = cval;
        pat_written[pid][cpos] = 1'b1;
        pat_len[pid] = (cval != 8'h00) ? cpos + 5'd1 : {1'b0, cpos};
      end
      mpsm_pkg::FUNC_RESTART: text_pos = 0;
      mpsm_pkg::FUNC_TEXT: begin
        if (cval == 8'h00) begin
          text_pos = 0;
        end else if (text_pos < TEXT_MAX) begin
          for (int k = PAT_LEN - 1; k > 0; k--) window[k] = window[k-1];
          window[0] = cval;
          end_idx = text_pos;
          text_pos++;
          for (int p = 0; p < NUM_PAT; p++) begin
            if (pattern_hits(p)) begin
              m.pat   = mpsm_pkg::MPAT_W'(p);
              m.start = mpsm_pkg::SPOS_W'(end_idx + 1 - int'(pat_len[p]));
              m.last  = 1'b0;
              if (n > 0) match_q.push_back(last_m);
              last_m = m;
              n++;
            end
          end
          if (n > 0) begin
            last_m.last = 1'b1;
            match_q.push_back(last_m);
          end
        end
      end
      default: ;
    endcase
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic mpsm_pkg::char_t text_char(int alpha);
    if ($urandom_range(0, 9) < 8)
      return mpsm_pkg::CHAR_W'(32'h61 + $urandom_range(0, alpha - 1));
    return mpsm_pkg::CHAR_W'($urandom_range(1, 255));
  endfunction

  // tvalid stays high into the next call unless that call opens a gap
  task automatic send_item(input logic [mpsm_pkg::FUNC_W-1:0] f,
                           input logic [mpsm_pkg::PID_W-1:0] pid,
                           input logic [mpsm_pkg::CPOS_W-1:0] cpos,
                           input mpsm_pkg::char_t cval);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {2'b00, cval, cpos, pid};
    do @(posedge clk); while (!s_axis_tready);
    sent_cnt++;
    predict_matches(f, pid, cpos, cval, last_n, last_hit);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [mpsm_pkg::PID_W-1:0] pid, input int len,
                              input int alpha);
    for (int j = 0; j < len; j++)
      send_item(mpsm_pkg::FUNC_PATTERN, pid, mpsm_pkg::CPOS_W'(j), text_char(alpha));
    if (len < PAT_LEN && $urandom_range(0, 1) == 1)
      send_item(mpsm_pkg::FUNC_PATTERN, pid, mpsm_pkg::CPOS_W'(len), 8'h00);
  endtask

  task automatic text_run(input int len, input int alpha);
    for (int i = 0; i < len; i++)
      send_item(mpsm_pkg::FUNC_TEXT, mpsm_pkg::PID_W'($urandom_range(0, 3)),
                mpsm_pkg::CPOS_W'($urandom_range(0, 15)), text_char(alpha));
    case ($urandom_range(0, 3))
      0: send_item(mpsm_pkg::FUNC_TEXT, mpsm_pkg::PID_W'($urandom_range(0, 3)),
                   mpsm_pkg::CPOS_W'($urandom_range(0, 15)), 8'h00);
      1: send_item(mpsm_pkg::FUNC_RESTART, mpsm_pkg::PID_W'($urandom_range(0, 3)),
                   mpsm_pkg::CPOS_W'($urandom_range(0, 15)),
                   mpsm_pkg::CHAR_W'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // single character write that never leaves a hole below the new length
  task automatic poke_pattern(input int alpha);
    logic [mpsm_pkg::PID_W-1:0] pid;
    int                         prefix;
    pid = mpsm_pkg::PID_W'($urandom_range(0, NUM_PAT - 1));
    prefix = 0;
    while (prefix < PAT_LEN && pat_written[pid][prefix]) prefix++;
    send_item(mpsm_pkg::FUNC_PATTERN, pid,
              mpsm_pkg::CPOS_W'($urandom_range(0, (prefix < PAT_LEN) ? prefix : PAT_LEN - 1)),
              ($urandom_range(0, 3) == 0) ? 8'h00 : text_char(alpha));
  endtask

  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall    <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady && $urandom_range(0, 4) == 0) sink_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pat   = m_axis_tdata[mpsm_pkg::MPAT_W-1:0];
      got.start = m_axis_tdata[mpsm_pkg::MPAT_W +: mpsm_pkg::SPOS_W];
      got.last  = m_axis_tlast;
      if (match_q.size() == 0) begin
        $error("unexpected match transaction: pattern %0d start %0d", got.pat, got.start);
        fail_cnt++;
      end else begin
        want = match_q.pop_front();
        if (got.pat !== want.pat) begin
          $error("match_pattern: expected %0d, got %0d", want.pat, got.pat);
          fail_cnt++;
        end
        if (got.start !== want.start) begin
          $error("start_position: expected %0d, got %0d", want.start, got.start);
          fail_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("multi_pattern_string_matcher_test: FAIL");
      $finish;
    end
  end

  initial begin
    int alpha;
    int stop_at;
    int r;
    for (int p = 0; p < NUM_PAT; p++) begin
      pat_len[p]     = '0;
      pat_written[p] = '0;
    end
    text_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].f, dir_tab[i].pid, dir_tab[i].cpos, dir_tab[i].cval);
      if (dir_tab[i].typed) begin
        if (last_n != dir_tab[i].n) begin
          $error("row %0d match count: expected %0d, got %0d", i, dir_tab[i].n, last_n);
          fail_cnt++;
        end else if (last_n > 0 && (last_hit.pat != dir_tab[i].lpat ||
                                    last_hit.start != dir_tab[i].lstart)) begin
          $error("row %0d final match: expected %0d@%0d, got %0d@%0d", i,
                 dir_tab[i].lpat, dir_tab[i].lstart, last_hit.pat, last_hit.start);
          fail_cnt++;
        end
      end
    end
    wait_drained();

    stop_at = sent_cnt + RANDOM_ITEMS;
    while (sent_cnt < stop_at) begin
      alpha = $urandom_range(1, 3);
      r = $urandom_range(0, 99);
      if (r < 20) begin
        load_pattern(mpsm_pkg::PID_W'($urandom_range(0, NUM_PAT - 1)),
                     ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                  : $urandom_range(5, PAT_LEN), alpha);
      end else if (r < 28) begin
        poke_pattern(alpha);
      end else if (r < 33) begin
        send_item(mpsm_pkg::FUNC_RESTART, mpsm_pkg::PID_W'($urandom_range(0, 3)),
                  mpsm_pkg::CPOS_W'($urandom_range(0, 15)),
                  mpsm_pkg::CHAR_W'($urandom_range(0, 255)));
      end else if (r < 35) begin
        send_item(FUNC_UNUSED, mpsm_pkg::PID_W'($urandom_range(0, 3)),
                  mpsm_pkg::CPOS_W'($urandom_range(0, 15)),
                  mpsm_pkg::CHAR_W'($urandom_range(0, 255)));
      end else begin
        text_run($urandom_range(1, 24), alpha);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
      if ($urandom_range(0, 9) == 0) steady = ~steady;
    end
    steady = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && match_q.size() == 0) begin
      $display("multi_pattern_string_matcher_test: PASS");
    end else begin
      $display("multi_pattern_string_matcher_test: FAIL");
    end
    $finish;
  end

endmodule
